FILE: rtl/core/cms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cms_pkg
// Shared types, widths and constants of the capsule strip generator.
// ----------------------------------------------------------------------------
package cms_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int MAX_SECTORS  = 31;
  localparam int MAX_STACKS   = 62;
  localparam int CORDIC_STEPS = 16;
  localparam int TRIG_W       = 20;   // signed Q16 sine/cosine
  localparam int DIV_NUM_W    = 6 + ANGLE_BITS;
  localparam int DIV_DEN_W    = 7;
  localparam int MUL_A_W      = 40;
  localparam int MUL_B_W      = TRIG_W;
  localparam int MUL_P_W      = MUL_A_W + MUL_B_W;
  localparam int COORD_W      = 18;
  localparam int ACC_W        = 28;   // coordinate before saturation

  localparam logic [TRIG_W-1:0] CORDIC_X0 = TRIG_W'(39797);

  // Configuration register indexes.
  localparam logic [1:0] REG_SECTOR_COUNT = 2'd0;
  localparam logic [1:0] REG_STACK_COUNT  = 2'd1;
  localparam logic [1:0] REG_RADIUS       = 2'd2;
  localparam logic [1:0] REG_HALF_HEIGHT  = 2'd3;

  typedef logic signed [TRIG_W-1:0] trig_t;

  // Arctangent of 2^-i as a fraction of a full turn, 32 bits.
  function automatic logic [31:0] atan_turn(input logic [3:0] i);
    logic [31:0] v;
    case (i)
      4'd0:    v = 32'h20000000;
      4'd1:    v = 32'h12E4051E;
      4'd2:    v = 32'h09FB385B;
      4'd3:    v = 32'h051111D4;
      4'd4:    v = 32'h028B0D43;
      4'd5:    v = 32'h0145D7E1;
      4'd6:    v = 32'h00A2F61E;
      4'd7:    v = 32'h00517C55;
      4'd8:    v = 32'h0028BE53;
      4'd9:    v = 32'h00145F2F;
      4'd10:   v = 32'h000A2F98;
      4'd11:   v = 32'h000517CC;
      4'd12:   v = 32'h00028BE6;
      4'd13:   v = 32'h000145F3;
      4'd14:   v = 32'h0000A2FA;
      4'd15:   v = 32'h0000517D;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/cms_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cms_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cms_div (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [cms_pkg::DIV_NUM_W-1:0]  num,
  input  wire logic [cms_pkg::DIV_DEN_W-1:0]  den,
  output logic                                done,
  output logic [cms_pkg::DIV_NUM_W-1:0]       quot
);
  import cms_pkg::*;

  localparam int CNT_W = $clog2(DIV_NUM_W);

  logic                   busy_r;
  logic                   done_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [DIV_NUM_W-1:0]   num_r;
  logic [DIV_NUM_W-1:0]   quot_r;
  logic [DIV_DEN_W-1:0]   den_r;
  logic [DIV_DEN_W-1:0]   rem_r;
  logic [DIV_DEN_W:0]     trial;
  logic [DIV_DEN_W:0]     diff;

  assign trial = {rem_r, num_r[DIV_NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == CNT_W'(DIV_NUM_W - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        num_r  <= num;
        den_r  <= den;
        rem_r  <= '0;
        quot_r <= '0;
      end else if (busy_r) begin
        num_r <= {num_r[DIV_NUM_W-2:0], 1'b0};
        if (!diff[DIV_DEN_W]) begin
          rem_r  <= diff[DIV_DEN_W-1:0];
          quot_r <= {quot_r[DIV_NUM_W-2:0], 1'b1};
        end else begin
          rem_r  <= trial[DIV_DEN_W-1:0];
          quot_r <= {quot_r[DIV_NUM_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_NUM_W - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule
`default_nettype wire

FILE: rtl/core/cms_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cms_cordic
// Iterative rotation CORDIC, one micro-rotation per cycle, then quadrant fix.
// ----------------------------------------------------------------------------
module cms_cordic (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic [cms_pkg::ANGLE_BITS-1:0]  phase,
  output logic                                 done,
  output cms_pkg::trig_t                       cos_q,
  output cms_pkg::trig_t                       sin_q
);
  import cms_pkg::*;

  logic                busy_r;
  logic                done_r;
  logic [3:0]          iter_r;
  logic [1:0]          quad_r;
  trig_t               x_r;
  trig_t               y_r;
  logic signed [32:0]  z_r;
  trig_t               cos_r;
  trig_t               sin_r;
  logic [31:0]         turn;
  trig_t               dx;
  trig_t               dy;
  trig_t               x_nxt;
  trig_t               y_nxt;
  logic signed [32:0]  z_nxt;
  logic signed [32:0]  ang;

  assign turn = {phase, {(32 - ANGLE_BITS){1'b0}}};
  assign dx   = y_r >>> iter_r;
  assign dy   = x_r >>> iter_r;
  assign ang  = $signed({1'b0, atan_turn(iter_r)});

  always_comb begin
    if (!z_r[32]) begin
      x_nxt = x_r - dx;
      y_nxt = y_r + dy;
      z_nxt = z_r - ang;
    end else begin
      x_nxt = x_r + dx;
      y_nxt = y_r - dy;
      z_nxt = z_r + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      done_r <= busy_r && !start && (iter_r == 4'(CORDIC_STEPS - 1));
      if (start) begin
        busy_r <= 1'b1;
        iter_r <= '0;
        quad_r <= turn[31:30];
        x_r    <= CORDIC_X0;
        y_r    <= '0;
        z_r    <= $signed({3'b000, turn[29:0]});
      end else if (busy_r) begin
        x_r    <= x_nxt;
        y_r    <= y_nxt;
        z_r    <= z_nxt;
        iter_r <= iter_r + 1'b1;
        if (iter_r == 4'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          case (quad_r)
            2'd0:    begin cos_r <= x_nxt;  sin_r <= y_nxt;  end
            2'd1:    begin cos_r <= -y_nxt; sin_r <= x_nxt;  end
            2'd2:    begin cos_r <= -x_nxt; sin_r <= -y_nxt; end
            default: begin cos_r <= y_nxt;  sin_r <= -x_nxt; end
          endcase
        end
      end
    end
  end

  assign done  = done_r;
  assign cos_q = cos_r;
  assign sin_q = sin_r;

endmodule
`default_nettype wire

FILE: rtl/core/cms_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cms_mul
// Signed shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module cms_mul (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  input  wire logic signed [cms_pkg::MUL_A_W-1:0]  a,
  input  wire logic signed [cms_pkg::MUL_B_W-1:0]  b,
  output logic                                     done,
  output logic signed [cms_pkg::MUL_P_W-1:0]       p
);
  import cms_pkg::*;

  localparam int CNT_W = $clog2(MUL_B_W);

  logic                       busy_r;
  logic                       done_r;
  logic [CNT_W-1:0]           cnt_r;
  logic signed [MUL_P_W-1:0]  acc_r;
  logic signed [MUL_P_W-1:0]  a_r;
  logic [MUL_B_W-1:0]         b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == CNT_W'(MUL_B_W - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        acc_r  <= '0;
        a_r    <= MUL_P_W'(a);
        b_r    <= b;
      end else if (busy_r) begin
        // The top multiplier bit carries negative weight.
        if (b_r[0]) begin
          if (cnt_r == CNT_W'(MUL_B_W - 1)) acc_r <= acc_r - a_r;
          else                              acc_r <= acc_r + a_r;
        end
        a_r   <= a_r <<< 1;
        b_r   <= b_r >> 1;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MUL_B_W - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule
`default_nettype wire

FILE: rtl/core/capsule_mesh_strip_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// capsule_mesh_strip_generator
// Emits the vertices of one quad strip of a UV capsule mesh per input item.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid, in_stall, in_strip_index      | item in
//  out     | out_valid, out_stall, out_pos_x/y/z,    | item out
//          | out_last_vertex, out_bad_strip          |
//  cfg     | cfg_we, cfg_index, cfg_wdata            | write only
//
// One strip item takes many cycles. A shared divider, a shared CORDIC and
// a shared serial multiplier do all arithmetic in turn. A bad strip index
// yields a single flagged item. Reset is synchronous and active low; it
// restores the register defaults. A stalled output item is held in the
// output register while the sequencer keeps computing the next vertex;
// input is stalled until a strip is done.
// ----------------------------------------------------------------------------
module capsule_mesh_strip_generator (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [5:0]                   in_strip_index,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [17:0]                out_pos_x,
  output logic signed [17:0]                out_pos_y,
  output logic signed [17:0]                out_pos_z,
  output logic                              out_last_vertex,
  output logic                              out_bad_strip,
  input  wire logic                         cfg_we,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [15:0]                  cfg_wdata
);
  import cms_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PDIV, S_PCOR, S_TDIV, S_TCOR, S_MUL, S_OUT
  } state_t;

  // Configuration registers.
  logic [4:0]   sec_cfg_r;
  logic [5:0]   stk_cfg_r;
  logic [15:0]  radius_r;
  logic [15:0]  hh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_cfg_r <= 5'd16;
      stk_cfg_r <= 6'd16;
      radius_r  <= 16'd256;
      hh_r      <= 16'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SECTOR_COUNT: sec_cfg_r <= cfg_wdata[4:0];
        REG_STACK_COUNT:  stk_cfg_r <= cfg_wdata[5:0];
        REG_RADIUS:       radius_r  <= cfg_wdata;
        REG_HALF_HEIGHT:  hh_r      <= cfg_wdata;
        default:          ;
      endcase
    end
  end

  // Counts clamped into their useful ranges.
  logic [4:0] sec_sat;
  logic [5:0] stk_sat;

  always_comb begin
    if (sec_cfg_r < 5'd3)                   sec_sat = 5'd3;
    else if (sec_cfg_r > 5'(MAX_SECTORS))   sec_sat = 5'(MAX_SECTORS);
    else                                    sec_sat = sec_cfg_r;
    if (stk_cfg_r < 6'd2)                   stk_sat = 6'd2;
    else if (stk_cfg_r > 6'(MAX_STACKS))    stk_sat = 6'(MAX_STACKS);
    else                                    stk_sat = stk_cfg_r;
  end

  // Sequencer state.
  state_t                     state_r;
  logic                       go_r;
  logic                       go_nxt;
  logic [4:0]                 sec_r;
  logic [5:0]                 stk_r;
  logic [5:0]                 lat_r;
  logic                       cyl_r;
  logic                       top_r;
  logic                       bad_r;
  logic [4:0]                 lon_r;
  logic                       k_r;
  logic [2:0]                 mstep_r;
  trig_t                      cp_r;
  trig_t                      sp_r;
  trig_t                      ct_r;
  trig_t                      st_r;
  logic signed [MUL_P_W-1:0]  p_r;
  logic signed [ACC_W-1:0]    x_r;
  logic signed [ACC_W-1:0]    y_r;
  logic signed [ACC_W-1:0]    z_r;

  // Output register.
  logic                       out_valid_r;
  logic signed [COORD_W-1:0]  out_x_r;
  logic signed [COORD_W-1:0]  out_y_r;
  logic signed [COORD_W-1:0]  out_z_r;
  logic                       out_last_r;
  logic                       out_bad_r;

  // Shared units.
  logic                        div_done;
  logic [DIV_NUM_W-1:0]        div_quot;
  logic [DIV_NUM_W-1:0]        div_num;
  logic [DIV_DEN_W-1:0]        div_den;
  logic                        cor_done;
  trig_t                       cor_cos;
  trig_t                       cor_sin;
  logic                        mul_done;
  logic signed [MUL_P_W-1:0]   mul_p;
  logic signed [MUL_A_W-1:0]   mul_a;
  trig_t                       mul_b;
  logic [5:0]                  lat_k;

  assign lat_k = lat_r + {5'd0, k_r};

  always_comb begin
    if (state_r == S_TDIV) begin
      div_num = {lat_k, {ANGLE_BITS{1'b0}}};
      div_den = {stk_r, 1'b0};
    end else begin
      div_num = {1'b0, lon_r, {ANGLE_BITS{1'b0}}};
      div_den = {2'b00, sec_r};
    end
  end

  always_comb begin
    case (mstep_r)
      3'd1:    begin mul_a = p_r[MUL_A_W-1:0];                 mul_b = st_r; end
      3'd2:    begin mul_a = $signed({24'd0, radius_r});       mul_b = sp_r; end
      3'd3:    begin mul_a = p_r[MUL_A_W-1:0];                 mul_b = st_r; end
      3'd4:    begin mul_a = $signed({24'd0, radius_r});       mul_b = ct_r; end
      default: begin mul_a = $signed({24'd0, radius_r});       mul_b = cp_r; end
    endcase
  end

  cms_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (go_r && (state_r == S_PDIV || state_r == S_TDIV)),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  cms_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (go_r && (state_r == S_PCOR || state_r == S_TCOR)),
    .phase (div_quot[ANGLE_BITS-1:0]),
    .done  (cor_done),
    .cos_q (cor_cos),
    .sin_q (cor_sin)
  );

  cms_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (go_r && state_r == S_MUL),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  // Round half up at bit 16 and at bit 32 (floor shift after the bias).
  logic signed [MUL_P_W-1:0]  p_rnd16;
  logic signed [MUL_P_W-1:0]  p_rnd32;
  logic signed [ACC_W-1:0]    r16;
  logic signed [ACC_W-1:0]    r32;
  logic signed [ACC_W-1:0]    hh_pos;
  logic signed [ACC_W-1:0]    off;

  assign p_rnd16 = mul_p + MUL_P_W'(64'd32768);
  assign p_rnd32 = mul_p + MUL_P_W'(64'd2147483648);
  assign r16     = p_rnd16[ACC_W+15:16];
  assign r32     = p_rnd32[ACC_W+31:32];
  assign hh_pos  = $signed({12'd0, hh_r});
  assign off     = top_r ? hh_pos : -hh_pos;

  function automatic logic signed [COORD_W-1:0] sat(input logic signed [ACC_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > ACC_W'(131071))       r = COORD_W'(131071);
    else if (v < -ACC_W'(131072)) r = -COORD_W'(131072);
    else                          r = v[COORD_W-1:0];
    return r;
  endfunction

  logic out_free;
  logic last_lon;
  logic in_acc;

  assign out_free = !out_valid_r || !out_stall;
  assign last_lon = (lon_r == sec_r);
  assign in_acc   = in_valid && !in_stall;

  // A shared unit is started in the same cycle in which the sequencer enters
  // the step that owns it.
  always_comb begin
    case (state_r)
      S_IDLE:         go_nxt = in_acc && (in_strip_index <= stk_sat);
      S_PDIV, S_TDIV: go_nxt = div_done;
      S_PCOR, S_TCOR: go_nxt = cor_done;
      S_MUL:          go_nxt = mul_done && (cyl_r ? (mstep_r == 3'd0) : (mstep_r != 3'd4));
      S_OUT:          go_nxt = out_free && !bad_r && (k_r ? !last_lon : !cyl_r);
      default:        go_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
      lon_r       <= '0;
      k_r         <= 1'b0;
      mstep_r     <= '0;
      bad_r       <= 1'b0;
      cyl_r       <= 1'b0;
      top_r       <= 1'b0;
    end else begin
      go_r <= go_nxt;
      // In S_OUT the output register is refilled whenever it drains.
      if (out_valid_r && !out_stall && state_r != S_OUT) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            sec_r <= sec_sat;
            stk_r <= stk_sat;
            lon_r <= '0;
            k_r   <= 1'b0;
            cyl_r <= (in_strip_index == {1'b0, stk_sat[5:1]});
            top_r <= (in_strip_index < {1'b0, stk_sat[5:1]});
            lat_r <= (in_strip_index < {1'b0, stk_sat[5:1]}) ? in_strip_index
                                                              : in_strip_index - 6'd1;
            if (in_strip_index > stk_sat) begin
              bad_r   <= 1'b1;
              x_r     <= '0;
              y_r     <= '0;
              z_r     <= '0;
              state_r <= S_OUT;
            end else begin
              bad_r   <= 1'b0;
              state_r <= S_PDIV;
            end
          end
        end
        S_PDIV: begin
          if (div_done) begin
            state_r <= S_PCOR;
          end
        end
        S_PCOR: begin
          if (cor_done) begin
            cp_r    <= cor_cos;
            sp_r    <= cor_sin;
            mstep_r <= 3'd0;
            k_r     <= 1'b0;
            state_r <= cyl_r ? S_MUL : S_TDIV;
          end
        end
        S_TDIV: begin
          if (div_done) begin
            state_r <= S_TCOR;
          end
        end
        S_TCOR: begin
          if (cor_done) begin
            ct_r    <= cor_cos;
            st_r    <= cor_sin;
            mstep_r <= 3'd0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_done) begin
            p_r <= mul_p;
            if (cyl_r) begin
              if (mstep_r == 3'd0) begin
                x_r     <= r16;
                mstep_r <= 3'd2;
              end else begin
                z_r     <= r16;
                y_r     <= hh_pos;
                state_r <= S_OUT;
              end
            end else begin
              case (mstep_r)
                3'd1:    x_r <= r32;
                3'd3:    z_r <= r32;
                3'd4:    y_r <= r16 + off;
                default: ;
              endcase
              if (mstep_r == 3'd4) begin
                state_r <= S_OUT;
              end else begin
                mstep_r <= mstep_r + 3'd1;
              end
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_x_r     <= sat(x_r);
            out_y_r     <= sat(y_r);
            out_z_r     <= sat(z_r);
            out_last_r  <= bad_r || (last_lon && k_r);
            out_bad_r   <= bad_r;
            if (bad_r) begin
              state_r <= S_IDLE;
            end else if (!k_r) begin
              k_r <= 1'b1;
              if (cyl_r) begin
                y_r <= -hh_pos;
              end else begin
                state_r <= S_TDIV;
              end
            end else if (last_lon) begin
              state_r <= S_IDLE;
            end else begin
              lon_r   <= lon_r + 5'd1;
              state_r <= S_PDIV;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_pos_x       = out_x_r;
  assign out_pos_y       = out_y_r;
  assign out_pos_z       = out_z_r;
  assign out_last_vertex = out_last_r;
  assign out_bad_strip   = out_bad_r;

  // A bad strip is always a single item with zero coordinates.
  a_bad_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_bad_r |-> out_last_r && out_x_r == '0 && out_z_r == '0)
    else $error("bad strip item malformed");

  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_PDIV || state_r == S_TDIV))
    else $error("divider finished outside a divide step");

  a_cor_owner: assert property (@(posedge clk) disable iff (!rst_n)
    cor_done |-> (state_r == S_PCOR || state_r == S_TCOR))
    else $error("CORDIC finished outside a trig step");

  a_mul_owner: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r == S_MUL)
    else $error("multiplier finished outside a product step");

endmodule
`default_nettype wire
